>>> hw/rtl/char_lcd_nibble_expander_sequencer_assert.svh
// assertion macros for the lcd nibble expander sequencer checker
// used by the bound checker module only
`ifndef CHAR_LCD_NIBBLE_EXPANDER_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_EXPANDER_SEQUENCER_ASSERT_SVH

// clocked assertion, off while reset is held
`define LCDNX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also runs during reset
`define LCDNX_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/lcdnx_pkg.sv
// shared types, codes and constants of the lcd nibble expander sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lcdnx_pkg;

    // request kinds carried on tuser
    localparam logic [2:0] MODE_CMD       = 3'd0;
    localparam logic [2:0] MODE_CHAR      = 3'd1;
    localparam logic [2:0] MODE_CURSOR    = 3'd2;
    localparam logic [2:0] MODE_BACKLIGHT = 3'd3;
    localparam logic [2:0] MODE_INIT      = 3'd4;

    // microcode store
    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] A_BYTE = 6'd0;
    localparam logic [PC_W-1:0] A_BL   = 6'd6;
    localparam logic [PC_W-1:0] A_INIT = 6'd7;

    // image operations
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_RS     = 3'd1;
    localparam logic [2:0] OP_RW_CLR = 3'd2;
    localparam logic [2:0] OP_NIB_E  = 3'd3;
    localparam logic [2:0] OP_E_CLR  = 3'd4;
    localparam logic [2:0] OP_BL     = 3'd5;

    // nibble sources
    localparam logic [1:0] NS_HI    = 2'd0;
    localparam logic [1:0] NS_LO    = 2'd1;
    localparam logic [1:0] NS_CONST = 2'd2;

    // init constants
    localparam logic [7:0] INIT_FUNC_SET = 8'h28;
    localparam logic [7:0] INIT_DISP_ON  = 8'h0C;
    localparam logic [7:0] INIT_CLEAR    = 8'h01;
    localparam logic [7:0] INIT_NIB_8BIT = 8'h03;
    localparam logic [7:0] INIT_NIB_4BIT = 8'h02;

    // cursor address bases are 0x80 and 0xC0: top bit set, row in bit 6
    localparam logic CURSOR_BASE_BIT = 1'b1;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] nsel;
        logic [7:0] cval;
        logic       ld_byte;
        logic       last;
    } t_cw;

    function automatic t_cw mk_cw(input logic [2:0] op, input logic [1:0] nsel,
                                  input logic [7:0] cval, input logic ld_byte,
                                  input logic last);
        t_cw w;
        w.op      = op;
        w.nsel    = nsel;
        w.cval    = cval;
        w.ld_byte = ld_byte;
        w.last    = last;
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lcdnx_ucode_rom.sv
// microcode store: one control word per step of the request programs
// depends on lcdnx_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcdnx_ucode_rom (
    input  wire logic [lcdnx_pkg::PC_W-1:0] i_pc,
    output lcdnx_pkg::t_cw                  o_cw
);

    always_comb begin
        case (i_pc)
            // byte transfer: command, character, cursor
            6'd0:  o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_RS,     lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd1:  o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_RW_CLR, lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd2:  o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd3:  o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd4:  o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E,  lcdnx_pkg::NS_LO, 8'h00, 1'b0, 1'b0);
            6'd5:  o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_LO, 8'h00, 1'b0, 1'b1);
            // backlight
            6'd6:  o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_BL,     lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b1);
            // init: plain images
            6'd7:  o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_CLEAR,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd8:  o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_RS,     lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd9:  o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_RW_CLR, lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            // init: wake-up nibbles
            6'd10: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E, lcdnx_pkg::NS_CONST,
                                           lcdnx_pkg::INIT_NIB_8BIT, 1'b0, 1'b0);
            6'd11: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd12: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E, lcdnx_pkg::NS_CONST,
                                           lcdnx_pkg::INIT_NIB_8BIT, 1'b0, 1'b0);
            6'd13: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd14: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E, lcdnx_pkg::NS_CONST,
                                           lcdnx_pkg::INIT_NIB_8BIT, 1'b0, 1'b0);
            6'd15: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd16: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E, lcdnx_pkg::NS_CONST,
                                           lcdnx_pkg::INIT_NIB_4BIT, 1'b0, 1'b0);
            6'd17: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            // init: function set
            6'd18: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_RS, lcdnx_pkg::NS_HI,
                                           lcdnx_pkg::INIT_FUNC_SET, 1'b1, 1'b0);
            6'd19: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_RW_CLR, lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd20: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd21: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd22: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E,  lcdnx_pkg::NS_LO, 8'h00, 1'b0, 1'b0);
            6'd23: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_LO, 8'h00, 1'b0, 1'b0);
            // init: display on
            6'd24: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_RS, lcdnx_pkg::NS_HI,
                                           lcdnx_pkg::INIT_DISP_ON, 1'b1, 1'b0);
            6'd25: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_RW_CLR, lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd26: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd27: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd28: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E,  lcdnx_pkg::NS_LO, 8'h00, 1'b0, 1'b0);
            6'd29: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_LO, 8'h00, 1'b0, 1'b0);
            // init: clear display
            6'd30: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_RS, lcdnx_pkg::NS_HI,
                                           lcdnx_pkg::INIT_CLEAR, 1'b1, 1'b0);
            6'd31: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_RW_CLR, lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd32: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd33: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_HI, 8'h00, 1'b0, 1'b0);
            6'd34: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_NIB_E,  lcdnx_pkg::NS_LO, 8'h00, 1'b0, 1'b0);
            6'd35: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR,  lcdnx_pkg::NS_LO, 8'h00, 1'b0, 1'b1);
            // unused addresses end the program
            default: o_cw = lcdnx_pkg::mk_cw(lcdnx_pkg::OP_E_CLR, lcdnx_pkg::NS_HI, 8'h00,
                                             1'b0, 1'b1);
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/lcdnx_image_dp.sv
// port image datapath: request byte and flag latches, image register updated per control word
// depends on lcdnx_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcdnx_image_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,      // request transfer, latch operands
    input  wire logic [2:0]     i_mode,
    input  wire logic [7:0]     i_value,
    input  wire logic [5:0]     i_column,
    input  wire logic           i_row,
    input  wire logic           i_backlight_on,
    input  wire logic           i_step,      // execute one control word
    input  wire lcdnx_pkg::t_cw i_cw,
    output logic      [7:0]     o_image
);

    logic [7:0] r_image, n_image;
    logic [7:0] r_byte, n_byte;
    logic       r_flag, n_flag;
    logic [3:0] w_nib;

    always_comb begin
        case (i_cw.nsel)
            lcdnx_pkg::NS_HI:    w_nib = r_byte[7:4];
            lcdnx_pkg::NS_LO:    w_nib = r_byte[3:0];
            lcdnx_pkg::NS_CONST: w_nib = i_cw.cval[3:0];
            default:             w_nib = r_byte[7:4];
        endcase
    end

    always_comb begin
        n_image = r_image;
        if (i_step) begin
            case (i_cw.op)
                lcdnx_pkg::OP_CLEAR:  n_image = 8'h00;
                lcdnx_pkg::OP_RS:     n_image = {r_image[7:1], r_flag};
                lcdnx_pkg::OP_RW_CLR: n_image = {r_image[7:2], 1'b0, r_image[0]};
                lcdnx_pkg::OP_NIB_E:  n_image = {w_nib, r_image[3], 1'b1, r_image[1:0]};
                lcdnx_pkg::OP_E_CLR:  n_image = {r_image[7:3], 1'b0, r_image[1:0]};
                lcdnx_pkg::OP_BL:     n_image = {r_image[7:4], r_flag, r_image[2:0]};
                default:              n_image = r_image;
            endcase
        end
    end

    always_comb begin
        n_byte = r_byte;
        n_flag = r_flag;
        if (i_load) begin
            n_byte = i_value;
            n_flag = 1'b0;
            case (i_mode)
                lcdnx_pkg::MODE_CHAR:      n_flag = 1'b1;
                // 0x80 + column or 0xC0 + column, column below 64
                lcdnx_pkg::MODE_CURSOR:    n_byte = {lcdnx_pkg::CURSOR_BASE_BIT, i_row, i_column};
                lcdnx_pkg::MODE_BACKLIGHT: n_flag = i_backlight_on;
                default:                   n_flag = 1'b0;
            endcase
        end else if (i_step && i_cw.ld_byte) begin
            n_byte = i_cw.cval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image <= 8'h00;
        end else begin
            r_image <= n_image;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_flag <= n_flag;
    end

    assign o_image = r_image;

endmodule

`default_nettype wire

>>> hw/rtl/char_lcd_nibble_expander_sequencer.sv
// Character LCD request sequencer producing port expander images for a 4-bit LCD bus.
// s_axis: one request per transfer. tuser = mode (0 cmd, 1 char, 2 cursor, 3 backlight,
// 4 init); tdata = value, column, row, backlight_on. Modes 5 to 7 are taken and dropped.
// m_axis: one port image per transfer on tdata, tlast on the final image of a request.
// Images per request: command, character and cursor give 6 images, backlight 1, init 29;
// one image per cycle from the microcode step counter while the output is not stalled.
// The next request is taken in the cycle its predecessor's last step runs.
// The request transfer loads the step counter; the first step then registers the first image.
// The image register is the output register: it holds while an image is pending and
// m_axis_tready is low, and the step counter stalls with it. s_axis_tready is low while
// a program runs, except in the cycle its last step runs.
// Reset clears the port image to zero and drops any run in progress.
// depends on lcdnx_pkg, lcdnx_ucode_rom, lcdnx_image_dp
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_expander_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // value[7:0], column[13:8], row[14], backlight_on[15]
    input  wire logic [2:0]  s_axis_tuser,   // mode[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // expander_byte[7:0]
    output logic             m_axis_tlast
);

    logic                          r_busy, n_busy;
    logic [lcdnx_pkg::PC_W-1:0]    r_pc, n_pc;
    logic                          r_valid, n_valid;
    logic                          r_last, n_last;
    logic                          w_step;
    logic                          w_load;
    logic                          w_known;
    lcdnx_pkg::t_cw                w_cw;
    logic [lcdnx_pkg::PC_W-1:0]    w_entry;

    lcdnx_ucode_rom u_rom (
        .i_pc (r_pc),
        .o_cw (w_cw)
    );

    // a step runs when the output slot is empty or being drained
    assign w_step        = r_busy && (!r_valid || m_axis_tready);
    assign s_axis_tready = !r_busy || (w_step && w_cw.last);
    assign w_load        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_known = 1'b1;
        case (s_axis_tuser)
            lcdnx_pkg::MODE_CMD,
            lcdnx_pkg::MODE_CHAR,
            lcdnx_pkg::MODE_CURSOR:    w_entry = lcdnx_pkg::A_BYTE;
            lcdnx_pkg::MODE_BACKLIGHT: w_entry = lcdnx_pkg::A_BL;
            lcdnx_pkg::MODE_INIT:      w_entry = lcdnx_pkg::A_INIT;
            default: begin
                w_entry = lcdnx_pkg::A_BYTE;
                w_known = 1'b0;
            end
        endcase
    end

    lcdnx_image_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_mode         (s_axis_tuser),
        .i_value        (s_axis_tdata[7:0]),
        .i_column       (s_axis_tdata[13:8]),
        .i_row          (s_axis_tdata[14]),
        .i_backlight_on (s_axis_tdata[15]),
        .i_step         (w_step),
        .i_cw           (w_cw),
        .o_image        (m_axis_tdata)
    );

    always_comb begin
        n_busy  = r_busy;
        n_pc    = r_pc;
        n_valid = r_valid;
        n_last  = r_last;
        if (r_valid && m_axis_tready) begin
            n_valid = 1'b0;
        end
        if (w_step) begin
            n_valid = 1'b1;
            n_last  = w_cw.last;
            n_pc    = r_pc + 1'b1;
            if (w_cw.last) begin
                n_busy = 1'b0;
            end
        end
        // unknown modes are dropped without a run
        if (w_load && w_known) begin
            n_busy = 1'b1;
            n_pc   = w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pc    <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_pc    <= n_pc;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

>>> hw/rtl/lcdnx_checker.sv
// port-level checks for the lcd nibble expander sequencer, bound to the top level
// depends on char_lcd_nibble_expander_sequencer_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "char_lcd_nibble_expander_sequencer_assert.svh"

module lcdnx_port_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // a stalled image holds
    `LCDNX_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled image changed")

    // no new request while a run is stalled midway
    `LCDNX_ASSERT(a_no_accept_mid_run, m_axis_tvalid && !m_axis_tlast && !m_axis_tready |-> !s_axis_tready, "request taken during a run")

    // a run never ends with the enable strobe high
    `LCDNX_ASSERT(a_e_low_at_end, m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tlast, "run ended with E high")

    // reset empties the output stage
    `LCDNX_ASSERT_RST(a_reset_flush, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind char_lcd_nibble_expander_sequencer lcdnx_port_checker u_lcdnx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
